FILE: sv/button_debounce_interval_setter_macros.svh
// Assertion macros used by the checker
`ifndef BUTTON_DEBOUNCE_INTERVAL_SETTER_MACROS_SVH
`define BUTTON_DEBOUNCE_INTERVAL_SETTER_MACROS_SVH

// implication checked at every clock edge outside reset
`define BDIS_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("bdis check failed");

// implication whose consequent is checked in the next cycle
`define BDIS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bdis check failed");

`endif

FILE: sv/bdis_pkg.sv
package bdis_pkg;

  localparam int unsigned MaxInterval = 120;
  localparam int unsigned HourClamp   = 18;
  localparam int unsigned SecPerMin   = 60;
  localparam int unsigned SecPerHour  = 3600;

  localparam logic [7:0] DebounceReset = 8'd20;

  localparam int unsigned NumButtons = 7;

  // served button codes: bit index plus one
  localparam logic [2:0] BtnNone    = 3'd0;
  localparam logic [2:0] BtnUp      = 3'd2;
  localparam logic [2:0] BtnReset   = 3'd3;
  localparam logic [2:0] BtnDown    = 3'd4;
  localparam logic [2:0] BtnParam   = 3'd5;
  localparam logic [2:0] BtnRunStop = 3'd7;

  localparam logic [1:0] UnitSec  = 2'd0;
  localparam logic [1:0] UnitMin  = 2'd1;
  localparam logic [1:0] UnitHour = 2'd2;

  typedef struct packed {
    logic [6:0]  count;
    logic [1:0]  unit;
    logic        halt;
    logic [15:0] secs;
  } bdis_setting_t;

  // highest pressed button as bit index plus one, 0 if none
  function automatic logic [2:0] highest_pressed(input logic [NumButtons-1:0] low_bits);
    logic [2:0] code;
    code = BtnNone;
    for (int i = 0; i < NumButtons; i++) begin
      if (low_bits[i]) begin
        code = 3'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

FILE: sv/bdis_serve.sv
module bdis_serve (
  input  bdis_pkg::bdis_setting_t cur,
  input  logic [2:0]              button,
  output bdis_pkg::bdis_setting_t upd,
  output logic                    recalc
);

  logic [6:0] cnt;
  logic [1:0] unit;

  always_comb begin
    cnt  = cur.count;
    unit = cur.unit;
    upd  = cur;

    if (button == bdis_pkg::BtnUp && cnt < 7'(bdis_pkg::MaxInterval)) begin
      cnt = cnt + 7'd1;
    end
    if (button == bdis_pkg::BtnDown && cnt > 7'd1) begin
      cnt = cnt - 7'd1;
    end
    if (button == bdis_pkg::BtnParam) begin
      unit = (cur.unit == bdis_pkg::UnitSec) ? bdis_pkg::UnitMin :
             (cur.unit == bdis_pkg::UnitMin) ? bdis_pkg::UnitHour : bdis_pkg::UnitSec;
    end
    if (button == bdis_pkg::BtnRunStop) begin
      upd.halt = ~cur.halt;
    end

    recalc = (button == bdis_pkg::BtnUp) || (button == bdis_pkg::BtnDown) ||
             (button == bdis_pkg::BtnParam) || (button == bdis_pkg::BtnReset);

    if (recalc) begin
      case (unit)
        bdis_pkg::UnitSec: upd.secs = {9'd0, cnt};
        bdis_pkg::UnitMin: upd.secs = 16'({9'd0, cnt} * 16'(bdis_pkg::SecPerMin));
        default: begin
          if (cnt > 7'(bdis_pkg::HourClamp)) begin
            cnt = 7'(bdis_pkg::HourClamp);
          end
          upd.secs = 16'({9'd0, cnt} * 16'(bdis_pkg::SecPerHour));
        end
      endcase
    end

    upd.count = cnt;
    upd.unit  = unit;
  end

endmodule

FILE: sv/button_debounce_interval_setter.sv
// Button debounce and interval setter.
// s_axis: one beat per millisecond tick, tdata[6:0] = active-low levels of the
//   seven buttons (display, up, reset, down, param, inject, run/stop).
// m_axis: one result beat per input beat, in order.
// cfg: debounce_ticks write, always ready; write only while idle (unenforced).
// A beat accepted on s_axis appears on m_axis in the next cycle, from the
// result register. Throughput is one beat per cycle while the receiver does
// not stall; the result register refills in the same cycle it is drained.
// When the receiver stalls, the result beat holds and s_axis_tready drops
// until it is taken.
// Reset: interval 1, unit seconds, 1 second, not stopped, detector idle,
// debounce_ticks 20, no result pending.
module button_debounce_interval_setter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [6:0] button_levels_n, [7] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [6:0] interval_value, [8:7] time_unit,
                                     // [24:9] interval_seconds, [25] stopped,
                                     // [26] restart_count, [27] clear_display,
                                     // [30:28] served_button, [31] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_PRESS,
    PH_RELEASE,
    PH_DONE
  } phase_t;

  phase_t                  phase, phase_next;
  logic [2:0]              pending, pending_next;
  logic [7:0]              left, left_next;
  logic [7:0]              ticks;
  bdis_pkg::bdis_setting_t setting, setting_upd, setting_next;
  logic                    recalc;
  logic [6:0]              pressed;
  logic                    serve;
  logic                    restart;
  logic                    accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign pressed       = ~s_axis_tdata[6:0];

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    left_next    = (left == 8'd0) ? 8'd0 : left - 8'd1;
    unique case (phase)
      PH_WAIT: begin
        if (pressed != 7'd0) begin
          phase_next   = PH_PRESS;
          pending_next = bdis_pkg::highest_pressed(pressed);
          left_next    = ticks;
        end
      end
      PH_PRESS: begin
        if (left_next == 8'd0) begin
          if (pressed != 7'd0) begin
            phase_next = PH_RELEASE;
          end else begin
            phase_next   = PH_WAIT;
            pending_next = bdis_pkg::BtnNone;
          end
        end
      end
      PH_RELEASE: begin
        if (left_next == 8'd0 && pressed == 7'd0) begin
          phase_next = PH_DONE;
          left_next  = ticks;
        end
      end
      PH_DONE: begin
      end
    endcase
  end

  assign serve = (phase_next == PH_DONE) && (left_next == 8'd0);

  bdis_serve u_serve (
    .cur    (setting),
    .button (pending_next),
    .upd    (setting_upd),
    .recalc (recalc)
  );

  assign setting_next = serve ? setting_upd : setting;
  assign restart      = (serve & recalc) | setting_next.halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      pending       <= bdis_pkg::BtnNone;
      left          <= 8'd0;
      ticks         <= bdis_pkg::DebounceReset;
      setting.count <= 7'd1;
      setting.unit  <= bdis_pkg::UnitSec;
      setting.halt  <= 1'b0;
      setting.secs  <= 16'd1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ticks <= cfg_data;
      end
      if (accept) begin
        setting <= setting_next;
        if (serve) begin
          phase   <= PH_WAIT;
          pending <= bdis_pkg::BtnNone;
          left    <= 8'd0;
        end else begin
          phase   <= phase_next;
          pending <= pending_next;
          left    <= left_next;
        end
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {1'b0,
                          serve ? pending_next : bdis_pkg::BtnNone,
                          serve,
                          restart,
                          setting_next.halt,
                          setting_next.secs,
                          setting_next.unit,
                          setting_next.count};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/bdis_checker.sv
`include "button_debounce_interval_setter_macros.svh"

module bdis_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled result beat holds
  `BDIS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // every accepted tick yields a result beat on the next cycle
  `BDIS_ASSERT_NEXT(a_one_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

  // a served button always comes with the display clear, and stop forces restart
  `BDIS_ASSERT_IMPL(a_serve_clear, m_axis_tvalid && m_axis_tdata[30:28] != 3'd0, m_axis_tdata[27] && (!m_axis_tdata[25] || m_axis_tdata[26]))

  // interval stays in range and unit is never 3
  `BDIS_ASSERT_IMPL(a_range, m_axis_tvalid, m_axis_tdata[6:0] != 7'd0 && m_axis_tdata[6:0] <= 7'd120 && m_axis_tdata[8:7] != 2'd3)

endmodule

bind button_debounce_interval_setter bdis_checker u_bdis_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/button_debounce_interval_setter_tb.sv
module button_debounce_interval_setter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {PhIdle, PhPress, PhHeld, PhSettle} det_phase_t;

  // packed to match m_axis_tdata[30:0]
  typedef struct packed {
    logic [2:0]  served;
    logic        clear;
    logic        restart;
    logic        stopped;
    logic [15:0] secs;
    logic [1:0]  unit;
    logic [6:0]  count;
  } tick_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h7f;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;

  // predictor state
  det_phase_t  det_phase = PhIdle;
  logic [2:0]  det_button = bdis_pkg::BtnNone;
  logic [7:0]  det_left = 8'd0;
  logic [7:0]  cfg_debounce = bdis_pkg::DebounceReset;
  logic [6:0]  ivl_count = 7'd1;
  logic [1:0]  ivl_unit = bdis_pkg::UnitSec;
  logic        ivl_halt = 1'b0;
  logic [15:0] ivl_secs = 16'd1;

  logic [6:0]  level_q[$];
  tick_out_t   due_q[$];
  tick_out_t   want, got;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int queued_total = 0;
  int beats_in = 0;
  int beats_out = 0;
  int fail_cnt = 0;
  int serve_cnt[8];
  int peak_count = 1;
  int clamp_cnt = 0;

  button_debounce_interval_setter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic tick_out_t next_tick(input logic [6:0] levels_n);
    logic [6:0]  down_bits;
    logic [31:0] secs;
    tick_out_t   r;
    down_bits = ~levels_n;
    r = '0;
    if (det_left != 0) det_left = det_left - 8'd1;
    case (det_phase)
      PhIdle: begin
        if (down_bits != 0) begin
          det_phase = PhPress;
          det_button = bdis_pkg::BtnNone;
          for (int b = 1; b <= 7; b++) begin
            if (down_bits[b-1]) det_button = 3'(b);
          end
          det_left = cfg_debounce;
        end
      end
      PhPress: begin
        if (det_left == 0) begin
          if (down_bits != 0) begin
            det_phase = PhHeld;
          end else begin
            det_phase = PhIdle;
            det_button = bdis_pkg::BtnNone;
          end
        end
      end
      PhHeld: begin
        if (det_left == 0 && down_bits == 0) begin
          det_phase = PhSettle;
          det_left = cfg_debounce;
        end
      end
      default: ;
    endcase

    if (det_phase == PhSettle && det_left == 0) begin
      if (det_button == bdis_pkg::BtnUp && ivl_count < bdis_pkg::MaxInterval) begin
        ivl_count = ivl_count + 7'd1;
      end
      if (det_button == bdis_pkg::BtnDown && ivl_count > 1) ivl_count = ivl_count - 7'd1;
      if (det_button == bdis_pkg::BtnParam) begin
        ivl_unit = (ivl_unit == bdis_pkg::UnitSec) ? bdis_pkg::UnitMin :
                   (ivl_unit == bdis_pkg::UnitMin) ? bdis_pkg::UnitHour : bdis_pkg::UnitSec;
      end
      if (det_button == bdis_pkg::BtnRunStop) ivl_halt = ~ivl_halt;
      if (det_button == bdis_pkg::BtnUp || det_button == bdis_pkg::BtnDown ||
          det_button == bdis_pkg::BtnParam || det_button == bdis_pkg::BtnReset) begin
        if (ivl_unit == bdis_pkg::UnitSec) begin
          secs = 32'(ivl_count);
        end else if (ivl_unit == bdis_pkg::UnitMin) begin
          secs = 32'(ivl_count) * bdis_pkg::SecPerMin;
        end else begin
          if (ivl_count > bdis_pkg::HourClamp) begin
            ivl_count = 7'(bdis_pkg::HourClamp);
            clamp_cnt++;
          end
          secs = 32'(ivl_count) * bdis_pkg::SecPerHour;
        end
        ivl_secs = secs[15:0];
        r.restart = 1'b1;
      end
      r.clear = 1'b1;
      r.served = det_button;
      serve_cnt[det_button]++;
      if (ivl_count > peak_count) peak_count = ivl_count;
      det_phase = PhIdle;
      det_button = bdis_pkg::BtnNone;
      det_left = 8'd0;
    end

    if (ivl_halt) r.restart = 1'b1;
    r.count = ivl_count;
    r.unit = ivl_unit;
    r.secs = ivl_secs;
    r.stopped = ivl_halt;
    return r;
  endfunction

  task automatic check_field(input string fname, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fail_cnt++;
      if (fail_cnt <= 40) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (level_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, level_q.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        got = m_axis_tdata[30:0];
        if (due_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result beat %h with nothing expected", $time, m_axis_tdata);
        end else begin
          want = due_q.pop_front();
          check_field("interval_value", want.count, got.count);
          check_field("time_unit", want.unit, got.unit);
          check_field("interval_seconds", want.secs, got.secs);
          check_field("stopped", want.stopped, got.stopped);
          check_field("restart_count", want.restart, got.restart);
          check_field("clear_display", want.clear, got.clear);
          check_field("served_button", want.served, got.served);
        end
      end
      if (cfg_valid && cfg_ready) cfg_debounce = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        due_q.push_back(next_tick(s_axis_tdata[6:0]));
        beats_in++;
      end
    end
  end

  task automatic push_level(input logic [6:0] lv);
    level_q.push_back(lv);
    queued_total++;
  endtask

  task automatic tap(input logic [6:0] low_bits);
    push_level(~low_bits);
    push_level(~low_bits);
    push_level(7'h7f);
  endtask

  // well-formed press: held past the debounce, released, then settle ticks
  task automatic press_run(input int idx, input int hold, input int settle);
    logic [6:0] bits;
    bits = 7'(1 << idx);
    if ($urandom_range(1)) bits = bits | (7'($urandom) & (bits - 7'd1));
    push_level(~bits);
    for (int i = 1; i < hold; i++) push_level(~(bits | 7'($urandom)));
    push_level(7'h7f);
    for (int i = 0; i < settle; i++) push_level(7'($urandom));
  endtask

  task automatic set_debounce(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (beats_in != queued_total || due_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int dbc, input int send_pct, input int stall_pct,
                           input int n_items, input int up_bias, input bit with_param,
                           input int mess_pct, input bit long_hold);
    int start;
    int chk;
    int idx;
    int pick;
    set_debounce(8'(dbc));
    send_idle_pct <= send_pct;
    recv_stall_pct <= stall_pct;
    start = queued_total;
    chk = (dbc == 0) ? 1 : dbc;
    while (queued_total - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < mess_pct / 2) begin
        repeat ($urandom_range(1, 4)) push_level(7'($urandom));
      end else if (pick < mess_pct) begin
        // bounce: let go before the press debounce ends
        push_level(~7'(1 << $urandom_range(6)));
        repeat ($urandom_range(0, chk - 1)) push_level(7'($urandom) & 7'h7e);
        repeat (chk + 1) push_level(7'h7f);
      end else begin
        if ($urandom_range(99) < up_bias) begin
          idx = bdis_pkg::BtnUp - 1;
        end else begin
          do idx = $urandom_range(6); while (!with_param && idx == bdis_pkg::BtnParam - 1);
        end
        press_run(idx, chk + 1 + $urandom_range(2), dbc + $urandom_range(2));
      end
    end
    if (long_hold) hold_left <= 300;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // one press at the reset debounce setting
    press_run($urandom_range(6), 22, 21);
    drain();

    set_debounce(8'd0);
    push_level(7'h7f);
    tap(7'h7f);
    tap(7'(1 << (bdis_pkg::BtnRunStop - 1)));
    tap(7'(1 << (bdis_pkg::BtnUp - 1)));
    tap(7'(1 << (bdis_pkg::BtnDown - 1)));
    tap(7'(1 << (bdis_pkg::BtnDown - 1)));
    tap(7'(1 << (bdis_pkg::BtnParam - 1)));
    tap(7'h01);
    tap(7'h20);
    tap(7'(1 << (bdis_pkg::BtnReset - 1)));
    push_level(~7'(1 << (bdis_pkg::BtnUp - 1)));
    push_level(7'h7f);
    drain();

    run_phase(0, 0, 0, 500, 97, 1'b0, 4, 1'b0);
    run_phase(1, 64, 0, 250, 30, 1'b1, 20, 1'b0);
    run_phase(3, 0, 64, 250, 30, 1'b1, 20, 1'b1);
    run_phase(2, 32, 32, 250, 25, 1'b1, 20, 1'b0);
    run_phase(255, 0, 0, 1, 0, 1'b1, 0, 1'b0);

    $display("Ran %0d ticks (%0d result beats) at debounce 20, 0, 1, 2, 3 and 255,",
             beats_in, beats_out);
    $display("serving up %0d, down %0d, param %0d, reset %0d, run/stop %0d;",
             serve_cnt[bdis_pkg::BtnUp], serve_cnt[bdis_pkg::BtnDown],
             serve_cnt[bdis_pkg::BtnParam], serve_cnt[bdis_pkg::BtnReset],
             serve_cnt[bdis_pkg::BtnRunStop]);
    $display("peak interval %0d, %0d hour clamps", peak_count, clamp_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("timeout: %0d of %0d ticks accepted", beats_in, queued_total);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
